// File: design/chdma_pkg.sv
// Package for the VRAM DMA and speed-switch unit: operation and mode codes,
// register addresses, address masks and the result payload type.
// Depends on nothing; used by the interfaces and the top level.
`default_nettype none

package chdma_pkg;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_TICK   = 2'd2,
      OP_SWITCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_GENERAL = 2'd1,
      MODE_HBLANK  = 2'd2
   } mode_type;

   localparam logic [7:0] REG_SPEED = 8'h4D;
   localparam logic [7:0] REG_HDMA1 = 8'h51;
   localparam logic [7:0] REG_HDMA4 = 8'h54;
   localparam logic [7:0] REG_HDMA5 = 8'h55;

   localparam logic [6:0] LINES_DONE = 7'h7F;
   localparam logic [7:0] VRAM_BASE_HI = 8'h80;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        copy_valid;
      logic [15:0] copy_src;
      logic [15:0] copy_dst;
      logic [7:0]  copy_lines;
      logic [10:0] video_ticks;
      logic [11:0] core_ticks;
   } rsp_payload_type;

   function automatic logic [7:0] addr_mask(input logic [1:0] idx);
      logic [7:0] mask;
      case (idx)
         2'd0: mask = 8'hFF;
         2'd1: mask = 8'hF0;
         2'd2: mask = 8'h1F;
         default: mask = 8'hF0;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

// File: design/chdma_if.sv
// Handshake interfaces for the request and response channels of the
// VRAM DMA unit. Depends on chdma_pkg for the operation type.
`default_nettype none

interface chdma_req_if;
   logic                 valid;
   logic                 ready;
   chdma_pkg::op_type    op;
   logic [7:0]           reg_addr;
   logic [7:0]           write_data;
   logic [7:0]           cpu_cycles;
   logic                 in_hblank;

   modport source (output valid, op, reg_addr, write_data, cpu_cycles, in_hblank,
                   input ready);
   modport sink (input valid, op, reg_addr, write_data, cpu_cycles, in_hblank,
                 output ready);
endinterface

interface chdma_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        copy_valid;
   logic [15:0] copy_src;
   logic [15:0] copy_dst;
   logic [7:0]  copy_lines;
   logic [10:0] video_ticks;
   logic [11:0] core_ticks;

   modport source (output valid, read_data, copy_valid, copy_src, copy_dst,
                   copy_lines, video_ticks, core_ticks, input ready);
   modport sink (input valid, read_data, copy_valid, copy_src, copy_dst,
                 copy_lines, video_ticks, core_ticks, output ready);
endinterface

`default_nettype wire

// File: design/cgb_hdma_speed_controller.sv
// VRAM DMA and speed-switch unit, top level.
// Depends on chdma_pkg and the channel interfaces in chdma_if.sv.
//
// Usage: every request transaction is a register write, a register read,
// a tick or a speed-switch event, and each one produces exactly one response
// transaction. Writes and reads reach the speed register and the five HDMA
// registers; a tick reports the copy command (source, destination and number
// of 16-byte lines) that the DMA issues during it, together with the cycles
// scaled for the video unit and for the timer.
// A request accepted at a clock edge has its response valid right after that
// edge. Throughput is one transaction per cycle while the receiver takes each
// response, since all state updates are done by one pass of adders and muxes in
// the accepting cycle and the response sits in a single output register.
// When the receiver stalls, the response register holds its contents and the
// request channel stays ready only in the cycle where the response is taken,
// so no transaction is lost. Synchronous reset clears the address bytes, the
// DMA state and the speed flags, and empties the response register.
`default_nettype none

module cgb_hdma_speed_controller (
   input  wire          clock,
   input  wire          reset,
   chdma_req_if.sink    req_chan,
   chdma_rsp_if.source  rsp_chan
);

   logic [7:0]                 addr_bytes_ff [4];
   logic [7:0]                 addr_bytes_in [4];
   logic [15:0]                cur_src_ff, cur_src_in;
   logic [15:0]                cur_dst_ff, cur_dst_in;
   logic [6:0]                 lines_left_ff, lines_left_in;
   chdma_pkg::mode_type        dma_mode_ff, dma_mode_in;
   logic                       double_speed_ff, double_speed_in;
   logic                       switch_armed_ff, switch_armed_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   chdma_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       accept;
   logic       active;
   logic [1:0] byte_idx;
   logic [7:0] lines;
   logic [7:0] cyc_scaled;
   logic [11:0] line_ticks;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign active = (dma_mode_ff == chdma_pkg::MODE_GENERAL) ||
                   (dma_mode_ff == chdma_pkg::MODE_HBLANK);
   assign byte_idx = 2'(req_chan.reg_addr[1:0] - 2'd1);

   always_comb begin
      addr_bytes_in = addr_bytes_ff;
      cur_src_in = cur_src_ff;
      cur_dst_in = cur_dst_ff;
      lines_left_in = lines_left_ff;
      dma_mode_in = dma_mode_ff;
      double_speed_in = double_speed_ff;
      switch_armed_in = switch_armed_ff;
      rsp_data_in = '0;
      lines = 8'd0;
      cyc_scaled = double_speed_ff ? {1'b0, req_chan.cpu_cycles[7:1]} : req_chan.cpu_cycles;
      line_ticks = 12'd0;

      case (req_chan.op)
         chdma_pkg::OP_WRITE: begin
            if (req_chan.reg_addr == chdma_pkg::REG_SPEED) begin
               switch_armed_in = req_chan.write_data[0];
            end else if (req_chan.reg_addr inside
                         {[chdma_pkg::REG_HDMA1:chdma_pkg::REG_HDMA4]}) begin
               addr_bytes_in[byte_idx] = req_chan.write_data & chdma_pkg::addr_mask(byte_idx);
            end else if (req_chan.reg_addr == chdma_pkg::REG_HDMA5) begin
               lines_left_in = req_chan.write_data[6:0];
               cur_src_in = {addr_bytes_ff[0], addr_bytes_ff[1]};
               cur_dst_in = {chdma_pkg::VRAM_BASE_HI | addr_bytes_ff[2], addr_bytes_ff[3]};
               if (active && !req_chan.write_data[7]) begin
                  dma_mode_in = chdma_pkg::MODE_IDLE;
               end else if (req_chan.write_data[7]) begin
                  dma_mode_in = chdma_pkg::MODE_HBLANK;
               end else begin
                  dma_mode_in = chdma_pkg::MODE_GENERAL;
               end
            end
         end
         chdma_pkg::OP_READ: begin
            if (req_chan.reg_addr == chdma_pkg::REG_SPEED) begin
               rsp_data_in.read_data = {double_speed_ff, 6'd0, switch_armed_ff};
            end else if (req_chan.reg_addr inside
                         {[chdma_pkg::REG_HDMA1:chdma_pkg::REG_HDMA4]}) begin
               rsp_data_in.read_data = addr_bytes_ff[byte_idx];
            end else if (req_chan.reg_addr == chdma_pkg::REG_HDMA5) begin
               rsp_data_in.read_data = {active, lines_left_ff};
            end
         end
         chdma_pkg::OP_TICK: begin
            if (dma_mode_ff == chdma_pkg::MODE_GENERAL) begin
               lines = {1'b0, lines_left_ff} + 8'd1;
               lines_left_in = chdma_pkg::LINES_DONE;
               dma_mode_in = chdma_pkg::MODE_IDLE;
            end else if (dma_mode_ff == chdma_pkg::MODE_HBLANK && req_chan.in_hblank) begin
               lines = 8'd1;
               if (lines_left_ff == 7'd0) begin
                  lines_left_in = chdma_pkg::LINES_DONE;
                  dma_mode_in = chdma_pkg::MODE_IDLE;
               end else begin
                  lines_left_in = lines_left_ff - 7'd1;
               end
            end
            if (lines != 8'd0) begin
               rsp_data_in.copy_valid = 1'b1;
               rsp_data_in.copy_src = cur_src_ff;
               rsp_data_in.copy_dst = cur_dst_ff;
               rsp_data_in.copy_lines = lines;
               cur_src_in = cur_src_ff + {4'd0, lines, 4'd0};
               cur_dst_in = cur_dst_ff + {4'd0, lines, 4'd0};
            end
            line_ticks = {1'b0, lines, 3'd0};
            rsp_data_in.video_ticks = {3'd0, cyc_scaled} + line_ticks[10:0];
            rsp_data_in.core_ticks = {4'd0, req_chan.cpu_cycles} +
                                     (double_speed_ff ? {line_ticks[10:0], 1'b0} : line_ticks);
         end
         default: begin
            if (switch_armed_ff) begin
               double_speed_in = !double_speed_ff;
               switch_armed_in = 1'b0;
            end
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_bytes_ff <= '{default: 8'd0};
         cur_src_ff <= 16'd0;
         cur_dst_ff <= 16'd0;
         lines_left_ff <= 7'd0;
         dma_mode_ff <= chdma_pkg::MODE_IDLE;
         double_speed_ff <= 1'b0;
         switch_armed_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            addr_bytes_ff <= addr_bytes_in;
            cur_src_ff <= cur_src_in;
            cur_dst_ff <= cur_dst_in;
            lines_left_ff <= lines_left_in;
            dma_mode_ff <= dma_mode_in;
            double_speed_ff <= double_speed_in;
            switch_armed_ff <= switch_armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff.read_data;
   assign rsp_chan.copy_valid = rsp_data_ff.copy_valid;
   assign rsp_chan.copy_src = rsp_data_ff.copy_src;
   assign rsp_chan.copy_dst = rsp_data_ff.copy_dst;
   assign rsp_chan.copy_lines = rsp_data_ff.copy_lines;
   assign rsp_chan.video_ticks = rsp_data_ff.video_ticks;
   assign rsp_chan.core_ticks = rsp_data_ff.core_ticks;

endmodule

`default_nettype wire

// File: tb/cgb_hdma_speed_controller_tb.sv
// Self-checking testbench for the VRAM DMA and speed-switch unit.
// Drives a directed table and then random register, tick and speed-switch
// transactions, checking every response against a table entry or a predictor.
// Depends on chdma_pkg, the channel interfaces and cgb_hdma_speed_controller.
`default_nettype none

module cgb_hdma_speed_controller_tb;

   typedef struct packed {
      chdma_pkg::op_type op;
      logic [7:0]        reg_addr;
      logic [7:0]        write_data;
      logic [7:0]        cpu_cycles;
      logic              in_hblank;
   } bus_item_type;

   typedef struct packed {
      bus_item_type               item;
      logic                       fixed;
      chdma_pkg::rsp_payload_type rsp;
   } directed_row_type;

   localparam logic [31:0] HDMA_BYTE_MASKS = 32'hFF_F0_1F_F0;
   localparam int RANDOM_ITEMS = 360;

   logic clock = 1'b0;
   logic reset;

   chdma_req_if req_bus ();
   chdma_rsp_if rsp_bus ();

   cgb_hdma_speed_controller i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always #4 clock = ~clock;

   logic [7:0]          hdma_byte [4];
   logic [15:0]         dma_src;
   logic [15:0]         dma_dst;
   logic [6:0]          lines_rem;
   chdma_pkg::mode_type dma_mode;
   logic                speed_dbl;
   logic                speed_armed;

   chdma_pkg::rsp_payload_type owed_rsp_q [$];
   directed_row_type           directed_rows [$];
   int                         error_count = 0;
   int                         items_sent = 0;
   bit                         quiet = 1'b0;
   bit                         hold_off_req = 1'b0;

   function automatic chdma_pkg::rsp_payload_type hdma_access_rsp(input bus_item_type it);
      chdma_pkg::rsp_payload_type r;
      logic [31:0]     mult;
      logic [31:0]     lines;
      logic [31:0]     step;
      logic [31:0]     ticks;
      logic [1:0]      idx;
      logic            active;
      r = '0;
      lines = 0;
      active = (dma_mode == chdma_pkg::MODE_GENERAL) || (dma_mode == chdma_pkg::MODE_HBLANK);
      idx = 2'(it.reg_addr - chdma_pkg::REG_HDMA1);
      case (it.op)
         chdma_pkg::OP_WRITE: begin
            if (it.reg_addr == chdma_pkg::REG_SPEED) begin
               speed_armed = it.write_data[0];
            end else if (it.reg_addr >= chdma_pkg::REG_HDMA1 &&
                         it.reg_addr <= chdma_pkg::REG_HDMA4) begin
               hdma_byte[idx] = it.write_data & HDMA_BYTE_MASKS[8*(3-idx) +: 8];
            end else if (it.reg_addr == chdma_pkg::REG_HDMA5) begin
               lines_rem = it.write_data[6:0];
               dma_src = {hdma_byte[0], hdma_byte[1]};
               dma_dst = {chdma_pkg::VRAM_BASE_HI, 8'h00} | {hdma_byte[2], hdma_byte[3]};
               if (active && !it.write_data[7]) begin
                  dma_mode = chdma_pkg::MODE_IDLE;
               end else begin
                  dma_mode = it.write_data[7] ? chdma_pkg::MODE_HBLANK : chdma_pkg::MODE_GENERAL;
               end
            end
         end
         chdma_pkg::OP_READ: begin
            if (it.reg_addr == chdma_pkg::REG_SPEED) begin
               r.read_data = {speed_dbl, 6'b0, speed_armed};
            end else if (it.reg_addr >= chdma_pkg::REG_HDMA1 &&
                         it.reg_addr <= chdma_pkg::REG_HDMA4) begin
               r.read_data = hdma_byte[idx];
            end else if (it.reg_addr == chdma_pkg::REG_HDMA5) begin
               r.read_data = {active, lines_rem};
            end
         end
         chdma_pkg::OP_TICK: begin
            mult = speed_dbl ? 32'd2 : 32'd1;
            if (dma_mode == chdma_pkg::MODE_GENERAL) begin
               lines = {25'd0, lines_rem} + 32'd1;
               lines_rem = chdma_pkg::LINES_DONE;
               dma_mode = chdma_pkg::MODE_IDLE;
            end else if (dma_mode == chdma_pkg::MODE_HBLANK && it.in_hblank) begin
               lines = 32'd1;
               if (lines_rem == 7'd0) begin
                  lines_rem = chdma_pkg::LINES_DONE;
                  dma_mode = chdma_pkg::MODE_IDLE;
               end else begin
                  lines_rem = lines_rem - 7'd1;
               end
            end
            if (lines != 0) begin
               r.copy_valid = 1'b1;
               r.copy_src = dma_src;
               r.copy_dst = dma_dst;
               r.copy_lines = lines[7:0];
               step = 32'd16 * lines;
               dma_src = dma_src + step[15:0];
               dma_dst = dma_dst + step[15:0];
            end
            ticks = {24'd0, it.cpu_cycles} / mult + 32'd8 * lines;
            r.video_ticks = ticks[10:0];
            ticks = {24'd0, it.cpu_cycles} + 32'd8 * lines * mult;
            r.core_ticks = ticks[11:0];
         end
         default: begin
            if (speed_armed) begin
               speed_dbl = !speed_dbl;
               speed_armed = 1'b0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic chdma_pkg::rsp_payload_type read_rsp(input logic [7:0] d);
      chdma_pkg::rsp_payload_type r;
      r = '0;
      r.read_data = d;
      return r;
   endfunction

   function automatic chdma_pkg::rsp_payload_type tick_rsp(input logic cv,
                                                           input logic [15:0] src,
                                                           input logic [15:0] dst,
                                                           input logic [7:0] n,
                                                           input logic [10:0] vt,
                                                           input logic [11:0] ct);
      chdma_pkg::rsp_payload_type r;
      r = '0;
      r.copy_valid = cv;
      r.copy_src = src;
      r.copy_dst = dst;
      r.copy_lines = n;
      r.video_ticks = vt;
      r.core_ticks = ct;
      return r;
   endfunction

   function automatic bus_item_type rand_item(input chdma_pkg::op_type op);
      bus_item_type it;
      it.op = op;
      it.reg_addr = 8'($urandom_range(0, 255));
      it.write_data = 8'($urandom_range(0, 255));
      it.cpu_cycles = 8'($urandom_range(0, 255));
      it.in_hblank = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic logic [7:0] pick_addr();
      logic [7:0] k;
      logic [7:0] a;
      if ($urandom_range(0, 99) < 75) begin
         k = 8'($urandom_range(0, 5));
         case (k)
            8'd0: a = chdma_pkg::REG_SPEED;
            8'd5: a = chdma_pkg::REG_HDMA5;
            default: a = chdma_pkg::REG_HDMA1 + k - 8'd1;
         endcase
      end else begin
         a = 8'($urandom_range(0, 255));
      end
      return a;
   endfunction

   task automatic add_row(input chdma_pkg::op_type op, input logic [7:0] a,
                          input logic [7:0] d, input logic [7:0] c, input logic hb,
                          input logic fixed, input chdma_pkg::rsp_payload_type rsp);
      directed_row_type row;
      row.item.op = op;
      row.item.reg_addr = a;
      row.item.write_data = d;
      row.item.cpu_cycles = c;
      row.item.in_hblank = hb;
      row.fixed = fixed;
      row.rsp = rsp;
      directed_rows.push_back(row);
   endtask

   task automatic drive_access(input bus_item_type it, input logic fixed,
                               input chdma_pkg::rsp_payload_type fixed_rsp);
      chdma_pkg::rsp_payload_type predicted;
      if (!quiet && $urandom_range(0, 99) < 11) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op <= it.op;
      req_bus.reg_addr <= it.reg_addr;
      req_bus.write_data <= it.write_data;
      req_bus.cpu_cycles <= it.cpu_cycles;
      req_bus.in_hblank <= it.in_hblank;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = hdma_access_rsp(it);
      owed_rsp_q.push_back(fixed ? fixed_rsp : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      chdma_pkg::rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_rsp_q.size() == 0) begin
            $display("%0t: response transaction with nothing expected, actual read_data %0h",
                     $time, rsp_bus.read_data);
            error_count++;
         end else begin
            want = owed_rsp_q.pop_front();
            check_field("read_data", 16'(want.read_data), 16'(rsp_bus.read_data));
            check_field("copy_valid", 16'(want.copy_valid), 16'(rsp_bus.copy_valid));
            check_field("copy_src", want.copy_src, rsp_bus.copy_src);
            check_field("copy_dst", want.copy_dst, rsp_bus.copy_dst);
            check_field("copy_lines", 16'(want.copy_lines), 16'(rsp_bus.copy_lines));
            check_field("video_ticks", 16'(want.video_ticks), 16'(rsp_bus.video_ticks));
            check_field("core_ticks", 16'(want.core_ticks), 16'(rsp_bus.core_ticks));
         end
      end
   end

   initial begin
      bit hold_off_done;
      hold_off_done = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (60) @(negedge clock);
         end else begin
            rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 11);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      bus_item_type it;
      int        k;
      int        n;
      int        pick;
      req_bus.valid = 1'b0;
      req_bus.op = chdma_pkg::OP_WRITE;
      req_bus.reg_addr = 8'h00;
      req_bus.write_data = 8'h00;
      req_bus.cpu_cycles = 8'h00;
      req_bus.in_hblank = 1'b0;
      reset = 1'b1;
      hdma_byte[0] = 8'h00;
      hdma_byte[1] = 8'h00;
      hdma_byte[2] = 8'h00;
      hdma_byte[3] = 8'h00;
      dma_src = 16'h0000;
      dma_dst = 16'h0000;
      lines_rem = 7'd0;
      dma_mode = chdma_pkg::MODE_IDLE;
      speed_dbl = 1'b0;
      speed_armed = 1'b0;

      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA5, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h00));
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_SPEED, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h00));
      add_row(chdma_pkg::OP_TICK, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1,
              tick_rsp(1'b0, 16'h0000, 16'h0000, 8'd0, 11'd255, 12'd255));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA1, 8'hFF, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA1 + 8'd1, 8'hFF, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA1 + 8'd2, 8'hFF, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA4, 8'hFF, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA1 + 8'd1, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'hF0));
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA1 + 8'd2, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h1F));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'h7F, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA5, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'hFF));
      add_row(chdma_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1,
              tick_rsp(1'b1, 16'hFFF0, 16'h9FF0, 8'd128, 11'd1024, 12'd1024));
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA5, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h7F));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_SPEED, 8'h01, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_SPEED, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h01));
      add_row(chdma_pkg::OP_SWITCH, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_SPEED, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h80));
      add_row(chdma_pkg::OP_SWITCH, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_SPEED, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h80));
      add_row(chdma_pkg::OP_TICK, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1,
              tick_rsp(1'b0, 16'h0000, 16'h0000, 8'd0, 11'd127, 12'd255));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'hFF, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_TICK, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_TICK, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, '0);
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'h00, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA5, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h00));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'h80, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_TICK, 8'h00, 8'h00, 8'h10, 1'b1, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA5, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h7F));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'h81, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'h83, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, chdma_pkg::REG_HDMA5, 8'h00, 8'h00, 1'b0, 1'b1,
              read_rsp(8'h83));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'h05, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_WRITE, 8'h56, 8'hAA, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_READ, 8'h56, 8'h00, 8'h00, 1'b0, 1'b1, read_rsp(8'h00));
      add_row(chdma_pkg::OP_WRITE, chdma_pkg::REG_HDMA5, 8'h7F, 8'h00, 1'b0, 1'b0, '0);
      add_row(chdma_pkg::OP_TICK, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1,
              tick_rsp(1'b1, 16'hFFF0, 16'h9FF0, 8'd128, 11'd1151, 12'd2303));

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_access(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].rsp);
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent >= 120) hold_off_req = 1'b1;
         quiet = (items_sent >= 220) && (items_sent < 320);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            for (k = 0; k < 4; k++) begin
               it = rand_item(chdma_pkg::OP_WRITE);
               it.reg_addr = chdma_pkg::REG_HDMA1 + k[7:0];
               drive_access(it, 1'b0, '0);
            end
            it = rand_item(chdma_pkg::OP_WRITE);
            it.reg_addr = chdma_pkg::REG_HDMA5;
            if ($urandom_range(0, 1) == 1) it.write_data[6:0] = 7'($urandom_range(0, 3));
            drive_access(it, 1'b0, '0);
            n = $urandom_range(1, 4);
            repeat (n) begin
               it = rand_item(chdma_pkg::OP_TICK);
               it.in_hblank = ($urandom_range(0, 3) != 0);
               drive_access(it, 1'b0, '0);
            end
            it = rand_item(chdma_pkg::OP_READ);
            it.reg_addr = chdma_pkg::REG_HDMA5;
            drive_access(it, 1'b0, '0);
         end else if (pick < 40) begin
            it = rand_item(chdma_pkg::OP_WRITE);
            it.reg_addr = chdma_pkg::REG_SPEED;
            drive_access(it, 1'b0, '0);
            drive_access(rand_item(chdma_pkg::OP_SWITCH), 1'b0, '0);
            it = rand_item(chdma_pkg::OP_READ);
            it.reg_addr = chdma_pkg::REG_SPEED;
            drive_access(it, 1'b0, '0);
            drive_access(rand_item(chdma_pkg::OP_TICK), 1'b0, '0);
         end else begin
            it = rand_item(chdma_pkg::op_type'($urandom_range(0, 3)));
            it.reg_addr = pick_addr();
            drive_access(it, 1'b0, '0);
         end
      end

      quiet = 1'b0;
      req_bus.valid <= 1'b0;
      while (owed_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
design/chdma_pkg.sv
design/chdma_if.sv
design/cgb_hdma_speed_controller.sv
tb/cgb_hdma_speed_controller_tb.sv
